>>> rtl/llex_pkg.sv
// Shared types, codes and event builders for the layout text lexer.
`default_nettype none
package llex_pkg;

  localparam logic [1:0] EV_APPEND = 2'd0;
  localparam logic [1:0] EV_CLOSE  = 2'd1;
  localparam logic [1:0] EV_ERROR  = 2'd2;
  localparam logic [1:0] EV_DONE   = 2'd3;

  localparam logic [1:0] TT_STRING = 2'd0;
  localparam logic [1:0] TT_IDENT  = 2'd1;
  localparam logic [1:0] TT_NUMBER = 2'd2;
  localparam logic [1:0] TT_OPER   = 2'd3;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_STRING = 3'd1;
  localparam logic [2:0] M_ESCAPE = 3'd2;
  localparam logic [2:0] M_NUMBER = 3'd3;
  localparam logic [2:0] M_IDENT  = 3'd4;

  localparam logic [3:0] ERR_QUOTE_NUM   = 4'd1;
  localparam logic [3:0] ERR_QUOTE_ID    = 4'd2;
  localparam logic [3:0] ERR_BAD_ESC     = 4'd3;
  localparam logic [3:0] ERR_ESC_POINT   = 4'd4;
  localparam logic [3:0] ERR_TWO_POINTS  = 4'd5;
  localparam logic [3:0] ERR_POINT_ID    = 4'd6;
  localparam logic [3:0] ERR_ESC_SPACE   = 4'd7;
  localparam logic [3:0] ERR_LETTER_NUM  = 4'd8;
  localparam logic [3:0] ERR_ILLEGAL     = 4'd9;
  localparam logic [3:0] ERR_OPEN_STR    = 4'd10;
  localparam logic [3:0] ERR_OPEN_ESC    = 4'd11;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_POINT  = 8'd46;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_EQUAL  = 8'd61;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_T      = 8'd116;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] ttype;
    logic [7:0] ch;
    logic [3:0] err;
  } ev_t;

  typedef struct packed {
    logic [1:0]     cnt;
    ev_t [2:0]      ev;
  } job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

  function automatic ev_t ev_append(input logic [7:0] c);
    ev_t e;
    e = '0;
    e.kind = EV_APPEND;
    e.ch = c;
    return e;
  endfunction

  function automatic ev_t ev_close(input logic [1:0] tt);
    ev_t e;
    e = '0;
    e.kind = EV_CLOSE;
    e.ttype = tt;
    return e;
  endfunction

  function automatic ev_t ev_error(input logic [3:0] code);
    ev_t e;
    e = '0;
    e.kind = EV_ERROR;
    e.err = code;
    return e;
  endfunction

  function automatic ev_t ev_done();
    ev_t e;
    e = '0;
    e.kind = EV_DONE;
    return e;
  endfunction

endpackage
`default_nettype wire

>>> rtl/llex_front.sv
// Front end: accepts bytes, classifies them, tracks lexer state, builds event jobs.
`default_nettype none
module llex_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_char_value,
  input  wire logic          in_end_of_text,
  input  wire llex_pkg::qstat_t q_stat,
  output logic               q_push,
  output llex_pkg::job_t     q_job
);

  logic [2:0] mode_r, mode_nxt;
  logic       point_r, point_nxt;
  logic       halt_r, halt_nxt;
  logic       take;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;

  always_comb begin
    logic [2:0]        m;
    logic [1:0]        k;
    llex_pkg::ev_t [2:0] ev;
    logic [7:0]        c;
    logic              is_space;
    logic              is_alpha;
    logic              is_digit;
    logic              do_fail;
    logic [3:0]        fcode;
    logic              do_close;

    c        = in_char_value;
    m        = (mode_r > llex_pkg::M_IDENT) ? llex_pkg::M_IDLE : mode_r;
    k        = 2'd0;
    ev       = '0;
    do_fail  = 1'b0;
    fcode    = '0;
    do_close = 1'b0;
    mode_nxt  = mode_r;
    point_nxt = point_r;
    halt_nxt  = halt_r;
    is_space = (c == llex_pkg::CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    is_alpha = (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    is_digit = (c >= llex_pkg::CH_ZERO) && (c <= llex_pkg::CH_NINE);

    if (in_end_of_text) begin
      if (!halt_r) begin
        if (mode_r == llex_pkg::M_STRING) begin
          ev[0] = llex_pkg::ev_error(llex_pkg::ERR_OPEN_STR);
          k = 2'd1;
        end else if (mode_r == llex_pkg::M_ESCAPE) begin
          ev[0] = llex_pkg::ev_error(llex_pkg::ERR_OPEN_ESC);
          k = 2'd1;
        end else begin
          if (mode_r == llex_pkg::M_NUMBER) begin
            ev[0] = llex_pkg::ev_close(llex_pkg::TT_NUMBER);
            k = 2'd1;
          end else if (mode_r == llex_pkg::M_IDENT) begin
            ev[0] = llex_pkg::ev_close(llex_pkg::TT_IDENT);
            k = 2'd1;
          end
          ev[k] = llex_pkg::ev_done();
          k = k + 2'd1;
        end
      end
      mode_nxt  = llex_pkg::M_IDLE;
      point_nxt = 1'b0;
      halt_nxt  = 1'b0;
    end else if (!halt_r) begin
      priority if (c == llex_pkg::CH_QUOTE) begin
        unique case (m)
          llex_pkg::M_IDLE: mode_nxt = llex_pkg::M_STRING;
          llex_pkg::M_STRING: begin
            ev[0] = llex_pkg::ev_close(llex_pkg::TT_STRING);
            k = 2'd1;
            mode_nxt = llex_pkg::M_IDLE;
          end
          llex_pkg::M_ESCAPE: begin
            ev[0] = llex_pkg::ev_append(llex_pkg::CH_QUOTE);
            k = 2'd1;
            mode_nxt = llex_pkg::M_STRING;
          end
          llex_pkg::M_NUMBER: begin
            do_fail = 1'b1;
            fcode = llex_pkg::ERR_QUOTE_NUM;
          end
          default: begin
            do_fail = 1'b1;
            fcode = llex_pkg::ERR_QUOTE_ID;
          end
        endcase
      end else if (c == llex_pkg::CH_EQUAL || c == llex_pkg::CH_COLON) begin
        if (m == llex_pkg::M_STRING) begin
          ev[0] = llex_pkg::ev_append(c);
          k = 2'd1;
        end else if (m == llex_pkg::M_ESCAPE) begin
          do_fail = 1'b1;
          fcode = llex_pkg::ERR_BAD_ESC;
        end else begin
          do_close = 1'b1;
        end
      end else if (c == llex_pkg::CH_POINT) begin
        unique case (m)
          llex_pkg::M_IDLE: begin
            ev[0] = llex_pkg::ev_append(llex_pkg::CH_ZERO);
            ev[1] = llex_pkg::ev_append(llex_pkg::CH_POINT);
            k = 2'd2;
            mode_nxt = llex_pkg::M_NUMBER;
            point_nxt = 1'b1;
          end
          llex_pkg::M_STRING: begin
            ev[0] = llex_pkg::ev_append(c);
            k = 2'd1;
          end
          llex_pkg::M_ESCAPE: begin
            do_fail = 1'b1;
            fcode = llex_pkg::ERR_ESC_POINT;
          end
          llex_pkg::M_NUMBER: begin
            if (point_r) begin
              do_fail = 1'b1;
              fcode = llex_pkg::ERR_TWO_POINTS;
            end else begin
              ev[0] = llex_pkg::ev_append(llex_pkg::CH_POINT);
              k = 2'd1;
              point_nxt = 1'b1;
            end
          end
          default: begin
            do_fail = 1'b1;
            fcode = llex_pkg::ERR_POINT_ID;
          end
        endcase
      end else if (is_space) begin
        if (m == llex_pkg::M_STRING) begin
          ev[0] = llex_pkg::ev_append(c);
          k = 2'd1;
        end else if (m == llex_pkg::M_ESCAPE) begin
          do_fail = 1'b1;
          fcode = llex_pkg::ERR_ESC_SPACE;
        end else begin
          do_close = 1'b1;
        end
      end else if (is_alpha) begin
        unique case (m)
          llex_pkg::M_IDLE: begin
            ev[0] = llex_pkg::ev_append(c);
            k = 2'd1;
            mode_nxt = llex_pkg::M_IDENT;
            point_nxt = 1'b0;
          end
          llex_pkg::M_ESCAPE: begin
            if (c == llex_pkg::CH_T) begin
              ev[0] = llex_pkg::ev_append(llex_pkg::CH_TAB);
              k = 2'd1;
              mode_nxt = llex_pkg::M_STRING;
            end else begin
              do_fail = 1'b1;
              fcode = llex_pkg::ERR_BAD_ESC;
            end
          end
          llex_pkg::M_NUMBER: begin
            do_fail = 1'b1;
            fcode = llex_pkg::ERR_LETTER_NUM;
          end
          default: begin
            ev[0] = llex_pkg::ev_append(c);
            k = 2'd1;
          end
        endcase
      end else if (is_digit) begin
        if (m == llex_pkg::M_IDLE) begin
          ev[0] = llex_pkg::ev_append(c);
          k = 2'd1;
          mode_nxt = llex_pkg::M_NUMBER;
          point_nxt = 1'b0;
        end else if (m == llex_pkg::M_ESCAPE) begin
          do_fail = 1'b1;
          fcode = llex_pkg::ERR_BAD_ESC;
        end else begin
          ev[0] = llex_pkg::ev_append(c);
          k = 2'd1;
        end
      end else if (c == llex_pkg::CH_BSLASH && m == llex_pkg::M_STRING) begin
        mode_nxt = llex_pkg::M_ESCAPE;
      end else if (m == llex_pkg::M_ESCAPE) begin
        do_fail = 1'b1;
        fcode = llex_pkg::ERR_BAD_ESC;
      end else begin
        do_fail = 1'b1;
        fcode = llex_pkg::ERR_ILLEGAL;
      end

      if (do_close) begin
        if (m == llex_pkg::M_NUMBER) begin
          ev[0] = llex_pkg::ev_close(llex_pkg::TT_NUMBER);
          k = 2'd1;
        end else if (m == llex_pkg::M_IDENT) begin
          ev[0] = llex_pkg::ev_close(llex_pkg::TT_IDENT);
          k = 2'd1;
        end
        mode_nxt  = llex_pkg::M_IDLE;
        point_nxt = 1'b0;
        if (!is_space) begin
          ev[k] = llex_pkg::ev_append(c);
          k = k + 2'd1;
          ev[k] = llex_pkg::ev_close(llex_pkg::TT_OPER);
          k = k + 2'd1;
        end
      end

      if (do_fail) begin
        ev[0] = llex_pkg::ev_error(fcode);
        k = 2'd1;
        mode_nxt  = llex_pkg::M_IDLE;
        point_nxt = 1'b0;
        halt_nxt  = 1'b1;
      end
    end

    q_job.cnt = k;
    q_job.ev  = ev;
    q_push    = take && (k != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= llex_pkg::M_IDLE;
      point_r <= 1'b0;
      halt_r  <= 1'b0;
    end else if (take) begin
      mode_r  <= mode_nxt;
      point_r <= point_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/llex_queue.sv
// Two-entry job queue between the front end and the event sequencer.
`default_nettype none
module llex_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire llex_pkg::job_t  push_job,
  input  wire logic            pop,
  output llex_pkg::job_t       head_job,
  output llex_pkg::qstat_t     stat
);

  localparam int PW = $clog2(llex_pkg::QDEPTH);
  localparam int CW = $clog2(llex_pkg::QDEPTH + 1);

  llex_pkg::job_t mem_r [llex_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(llex_pkg::QDEPTH));
  assign stat.valid = (cnt_r != '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(llex_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(llex_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/llex_back.sv
// Back end: plays out job events, one per cycle while out_ready is high.
`default_nettype none
module llex_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire llex_pkg::job_t  head_job,
  input  wire llex_pkg::qstat_t q_stat,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [1:0]           out_event_res,
  output logic [1:0]           out_token_type,
  output logic [7:0]           out_char_value_out,
  output logic [3:0]           out_error_code,
  output logic                 out_last_of_run
);

  llex_pkg::job_t job_r, job_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic           busy_r, busy_nxt;
  logic           last;
  logic           load;
  llex_pkg::ev_t  cur;

  assign cur   = job_r.ev[idx_r];
  assign last  = (idx_r == job_r.cnt - 2'd1);
  assign load  = !busy_r || (out_ready && last);
  assign q_pop = load && q_stat.valid;

  assign out_valid          = busy_r;
  assign out_event_res      = cur.kind;
  assign out_token_type     = cur.ttype;
  assign out_char_value_out = cur.ch;
  assign out_error_code     = cur.err;
  assign out_last_of_run    = last;

  always_comb begin
    job_nxt  = job_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (load) begin
      busy_nxt = q_stat.valid;
      job_nxt  = head_job;
      idx_nxt  = 2'd0;
    end else if (out_ready) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/layout_text_lexer_core.sv
// Top level of the layout text lexer: front end, job queue and event sequencer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_char_value, in_end_of_text
//   out      output     out_valid/out_ready  out_event_res, out_token_type,
//                                            out_char_value_out, out_error_code,
//                                            out_last_of_run
//
// An item is taken in the cycle it arrives while the two-entry job queue has room.
// Each item makes zero to three result items; the sequencer sends one per cycle while out_ready
// is high, and an item that makes none is not put into the job queue.
// Results pass through the job queue and the sequencer's job register on their way out.
// Synchronous active-low reset empties the queue and returns the lexer to idle.
// Output stalls back up through the queue to in_ready only.
`default_nettype none
module layout_text_lexer_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_value,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_event_res,
  output logic [1:0]      out_token_type,
  output logic [7:0]      out_char_value_out,
  output logic [3:0]      out_error_code,
  output logic            out_last_of_run
);

  llex_pkg::qstat_t q_stat;
  llex_pkg::job_t   push_job;
  llex_pkg::job_t   head_job;
  logic             q_push;
  logic             q_pop;

  llex_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_value  (in_char_value),
    .in_end_of_text (in_end_of_text),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  llex_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  llex_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_job           (head_job),
    .q_stat             (q_stat),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_token_type     (out_token_type),
    .out_char_value_out (out_char_value_out),
    .out_error_code     (out_error_code),
    .out_last_of_run    (out_last_of_run)
  );

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == llex_pkg::EV_DONE |-> out_last_of_run)
    else $error("done event not last of run");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == llex_pkg::EV_ERROR |-> out_last_of_run)
    else $error("error event not last of run");

  a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != llex_pkg::EV_CLOSE |-> out_token_type == 2'd0)
    else $error("token type set on non-close event");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

endmodule
`default_nettype wire

>>> dv/layout_text_lexer_core_tb.sv
// Self-checking testbench for layout_text_lexer_core: directed and random text streams checked per event.
`timescale 1ns / 1ps
module layout_text_lexer_core_tb;

  typedef struct {
    logic [1:0] kind;
    logic [1:0] ttype;
    logic [7:0] ch;
    logic [3:0] err;
    logic       last;
  } lex_event_t;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_value = '0;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_event_res;
  logic [1:0] out_token_type;
  logic [7:0] out_char_value_out;
  logic [3:0] out_error_code;
  logic       out_last_of_run;

  layout_text_lexer_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_value      (in_char_value),
    .in_end_of_text     (in_end_of_text),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_token_type     (out_token_type),
    .out_char_value_out (out_char_value_out),
    .out_error_code     (out_error_code),
    .out_last_of_run    (out_last_of_run)
  );

  always #5 clk = ~clk;

  text_item_t text_queue[$];
  lex_event_t expected_events[$];
  int         items_total = 0;
  int         items_taken = 0;
  int         mismatches = 0;

  logic [2:0] lex_mode = llex_pkg::M_IDLE;
  logic       lex_point = 1'b0;
  logic       lex_halted = 1'b0;

  int in_gap = 0;
  int in_calm_left = 0;
  bit in_calm = 1'b0;
  int out_stall = 0;
  int out_calm_left = 0;
  bit out_calm = 1'b0;

  function automatic int next_wait(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = int'($urandom_range(5, 30));
    end
    left--;
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == llex_pkg::CH_SPACE || (c >= llex_pkg::CH_TAB && c <= 8'd13);
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= llex_pkg::CH_ZERO && c <= llex_pkg::CH_NINE;
  endfunction

  task automatic note_event(input logic [1:0] kind, input logic [1:0] tt,
                            input logic [7:0] ch, input logic [3:0] err);
    lex_event_t e;
    e.kind = kind;
    e.ttype = tt;
    e.ch = ch;
    e.err = err;
    e.last = 1'b0;
    expected_events.insert(expected_events.size(), e);
  endtask

  task automatic lex_fail(input logic [3:0] code);
    note_event(llex_pkg::EV_ERROR, '0, '0, code);
    lex_mode = llex_pkg::M_IDLE;
    lex_point = 1'b0;
    lex_halted = 1'b1;
  endtask

  task automatic close_token();
    if (lex_mode == llex_pkg::M_NUMBER)
      note_event(llex_pkg::EV_CLOSE, llex_pkg::TT_NUMBER, '0, '0);
    else if (lex_mode == llex_pkg::M_IDENT)
      note_event(llex_pkg::EV_CLOSE, llex_pkg::TT_IDENT, '0, '0);
    lex_mode = llex_pkg::M_IDLE;
    lex_point = 1'b0;
  endtask

  task automatic lex_char(input logic [7:0] c);
    logic [2:0] m;
    m = (lex_mode > llex_pkg::M_IDENT) ? llex_pkg::M_IDLE : lex_mode;
    if (c == llex_pkg::CH_QUOTE) begin
      if (m == llex_pkg::M_IDLE) lex_mode = llex_pkg::M_STRING;
      else if (m == llex_pkg::M_STRING) begin
        note_event(llex_pkg::EV_CLOSE, llex_pkg::TT_STRING, '0, '0);
        lex_mode = llex_pkg::M_IDLE;
      end else if (m == llex_pkg::M_ESCAPE) begin
        note_event(llex_pkg::EV_APPEND, '0, llex_pkg::CH_QUOTE, '0);
        lex_mode = llex_pkg::M_STRING;
      end else if (m == llex_pkg::M_NUMBER) lex_fail(llex_pkg::ERR_QUOTE_NUM);
      else lex_fail(llex_pkg::ERR_QUOTE_ID);
    end else if (c == llex_pkg::CH_EQUAL || c == llex_pkg::CH_COLON) begin
      if (m == llex_pkg::M_STRING) note_event(llex_pkg::EV_APPEND, '0, c, '0);
      else if (m == llex_pkg::M_ESCAPE) lex_fail(llex_pkg::ERR_BAD_ESC);
      else begin
        close_token();
        note_event(llex_pkg::EV_APPEND, '0, c, '0);
        note_event(llex_pkg::EV_CLOSE, llex_pkg::TT_OPER, '0, '0);
      end
    end else if (c == llex_pkg::CH_POINT) begin
      if (m == llex_pkg::M_IDLE) begin
        note_event(llex_pkg::EV_APPEND, '0, llex_pkg::CH_ZERO, '0);
        note_event(llex_pkg::EV_APPEND, '0, llex_pkg::CH_POINT, '0);
        lex_mode = llex_pkg::M_NUMBER;
        lex_point = 1'b1;
      end else if (m == llex_pkg::M_STRING) note_event(llex_pkg::EV_APPEND, '0, c, '0);
      else if (m == llex_pkg::M_ESCAPE) lex_fail(llex_pkg::ERR_ESC_POINT);
      else if (m == llex_pkg::M_NUMBER) begin
        if (lex_point) lex_fail(llex_pkg::ERR_TWO_POINTS);
        else begin
          note_event(llex_pkg::EV_APPEND, '0, llex_pkg::CH_POINT, '0);
          lex_point = 1'b1;
        end
      end else lex_fail(llex_pkg::ERR_POINT_ID);
    end else if (is_blank(c)) begin
      if (m == llex_pkg::M_STRING) note_event(llex_pkg::EV_APPEND, '0, c, '0);
      else if (m == llex_pkg::M_ESCAPE) lex_fail(llex_pkg::ERR_ESC_SPACE);
      else close_token();
    end else if (is_letter(c)) begin
      if (m == llex_pkg::M_IDLE) begin
        note_event(llex_pkg::EV_APPEND, '0, c, '0);
        lex_mode = llex_pkg::M_IDENT;
        lex_point = 1'b0;
      end else if (m == llex_pkg::M_ESCAPE) begin
        if (c == llex_pkg::CH_T) begin
          note_event(llex_pkg::EV_APPEND, '0, llex_pkg::CH_TAB, '0);
          lex_mode = llex_pkg::M_STRING;
        end else lex_fail(llex_pkg::ERR_BAD_ESC);
      end else if (m == llex_pkg::M_NUMBER) lex_fail(llex_pkg::ERR_LETTER_NUM);
      else note_event(llex_pkg::EV_APPEND, '0, c, '0);
    end else if (is_digit(c)) begin
      if (m == llex_pkg::M_IDLE) begin
        note_event(llex_pkg::EV_APPEND, '0, c, '0);
        lex_mode = llex_pkg::M_NUMBER;
        lex_point = 1'b0;
      end else if (m == llex_pkg::M_ESCAPE) lex_fail(llex_pkg::ERR_BAD_ESC);
      else note_event(llex_pkg::EV_APPEND, '0, c, '0);
    end else if (c == llex_pkg::CH_BSLASH && m == llex_pkg::M_STRING) begin
      lex_mode = llex_pkg::M_ESCAPE;
    end else if (m == llex_pkg::M_ESCAPE) begin
      lex_fail(llex_pkg::ERR_BAD_ESC);
    end else begin
      lex_fail(llex_pkg::ERR_ILLEGAL);
    end
  endtask

  task automatic lex_step(input logic [7:0] c, input logic eot);
    int first;
    int idx;
    first = expected_events.size();
    if (eot) begin
      if (!lex_halted) begin
        if (lex_mode == llex_pkg::M_STRING)
          note_event(llex_pkg::EV_ERROR, '0, '0, llex_pkg::ERR_OPEN_STR);
        else if (lex_mode == llex_pkg::M_ESCAPE)
          note_event(llex_pkg::EV_ERROR, '0, '0, llex_pkg::ERR_OPEN_ESC);
        else begin
          close_token();
          note_event(llex_pkg::EV_DONE, '0, '0, '0);
        end
      end
      lex_mode = llex_pkg::M_IDLE;
      lex_point = 1'b0;
      lex_halted = 1'b0;
    end else if (!lex_halted) begin
      lex_char(c);
    end
    if (expected_events.size() > first) begin
      idx = expected_events.size() - 1;
      expected_events[idx].last = 1'b1;
    end
  endtask

  task automatic add_byte(input logic [7:0] c);
    text_item_t t;
    t.ch = c;
    t.eot = 1'b0;
    text_queue.insert(text_queue.size(), t);
  endtask

  task automatic add_end();
    text_item_t t;
    t.ch = 8'($urandom_range(0, 255));
    t.eot = 1'b1;
    text_queue.insert(text_queue.size(), t);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) != 0) ? 8'("A" + $urandom_range(0, 25))
                                       : 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(llex_pkg::CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 5) == 0) ? 8'(llex_pkg::CH_TAB + $urandom_range(0, 4))
                                       : llex_pkg::CH_SPACE;
  endfunction

  task automatic add_string();
    int n;
    add_byte(llex_pkg::CH_QUOTE);
    n = $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 11))
        0, 1, 2: add_byte(rand_letter());
        3, 4:    add_byte(rand_digit());
        5:       add_byte(rand_blank());
        6:       add_byte(($urandom_range(0, 2) == 0) ? llex_pkg::CH_POINT :
                          (($urandom_range(0, 1) != 0) ? llex_pkg::CH_EQUAL
                                                       : llex_pkg::CH_COLON));
        7: begin
          add_byte(llex_pkg::CH_BSLASH);
          add_byte(($urandom_range(0, 1) != 0) ? llex_pkg::CH_T : llex_pkg::CH_QUOTE);
        end
        8: begin
          add_byte(llex_pkg::CH_BSLASH);
          add_byte(8'($urandom_range(0, 255)));
        end
        9:       add_byte(8'($urandom_range(0, 255)));
        default: add_byte(8'("a" + $urandom_range(0, 25)));
      endcase
    end
    if ($urandom_range(0, 9) == 0) add_byte(llex_pkg::CH_BSLASH);
    if ($urandom_range(0, 7) != 0) add_byte(llex_pkg::CH_QUOTE);
  endtask

  task automatic add_number();
    int n;
    if ($urandom_range(0, 3) == 0) add_byte(llex_pkg::CH_POINT);
    else begin
      n = $urandom_range(1, 3);
      repeat (n) add_byte(rand_digit());
      if ($urandom_range(0, 1) != 0) add_byte(llex_pkg::CH_POINT);
    end
    n = $urandom_range(0, 2);
    repeat (n) add_byte(rand_digit());
    if ($urandom_range(0, 12) == 0) add_byte(llex_pkg::CH_POINT);
  endtask

  task automatic add_ident();
    int n;
    add_byte(rand_letter());
    n = $urandom_range(0, 4);
    repeat (n) add_byte(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
  endtask

  task automatic add_random_text();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(0, 13))
        0, 1, 2: add_ident();
        3, 4, 5: add_number();
        6, 7, 8: add_string();
        9, 10:   add_byte(($urandom_range(0, 1) != 0) ? llex_pkg::CH_EQUAL
                                                      : llex_pkg::CH_COLON);
        11:      add_byte(rand_blank());
        12:      add_byte(8'($urandom_range(0, 255)));
        default: add_byte(($urandom_range(0, 1) != 0) ? llex_pkg::CH_BSLASH
                                                      : 8'(8'hFF - $urandom_range(0, 127)));
      endcase
      if ($urandom_range(0, 4) != 0) add_byte(rand_blank());
    end
    add_end();
  endtask

  always @(posedge clk) begin : drive
    text_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        lex_step(in_char_value, in_end_of_text);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (text_queue.size() != 0) begin
          nxt = text_queue.pop_front();
          in_valid <= 1'b1;
          in_char_value <= nxt.ch;
          in_end_of_text <= nxt.eot;
          in_gap <= next_wait(in_calm_left, in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    lex_event_t want;
    int stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: ev=%0d tt=%0d ch=%0d err=%0d last=%0d",
                     out_event_res, out_token_type, out_char_value_out,
                     out_error_code, out_last_of_run);
        end else begin
          want = expected_events.pop_front();
          if (out_event_res !== want.kind || out_token_type !== want.ttype ||
              out_char_value_out !== want.ch || out_error_code !== want.err ||
              out_last_of_run !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected ev=%0d tt=%0d ch=%0d err=%0d last=%0d,",
                        " got ev=%0d tt=%0d ch=%0d err=%0d last=%0d"},
                       want.kind, want.ttype, want.ch, want.err, want.last,
                       out_event_res, out_token_type, out_char_value_out,
                       out_error_code, out_last_of_run);
          end
        end
        stall = next_wait(out_calm_left, out_calm);
        out_stall <= stall;
        out_ready <= (stall == 0);
      end else if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= (out_stall == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    add_text("\"\"");
    add_end();
    add_text("x1=.5 ");
    add_end();
    add_text("\"\\t\\\"");
    add_end();
    add_text("\"\\");
    add_end();
    add_byte(llex_pkg::CH_BSLASH);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_end();
    while (text_queue.size() < 440) add_random_text();
    items_total = text_queue.size();

    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken < items_total || expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("PASS layout_text_lexer_core");
    else $display("FAIL layout_text_lexer_core");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL layout_text_lexer_core");
    $finish;
  end

endmodule

>>> files.f
rtl/llex_pkg.sv
rtl/llex_front.sv
rtl/llex_queue.sv
rtl/llex_back.sv
rtl/layout_text_lexer_core.sv
dv/layout_text_lexer_core_tb.sv
